// ===== rtl/fr_pkg.sv =====
// Package: shared constants, register codes and structs of the find-and-replace block.
package fr_pkg;

	localparam int BYTE_W    = 8;
	localparam int CFG_BYTES = 8;
	localparam int LEN_W     = 4;
	localparam int TOTAL_W   = 16;
	localparam int ADDR_W    = 6;
	localparam int DATA_W    = 64;
	localparam int IDX_LSB   = 3;

	localparam logic [2:0] REG_PATTERN      = 3'd0;
	localparam logic [2:0] REG_PATTERN_LEN  = 3'd1;
	localparam logic [2:0] REG_REPLACE      = 3'd2;
	localparam logic [2:0] REG_REPLACE_LEN  = 3'd3;
	localparam logic [2:0] REG_EVERY        = 3'd4;

	typedef struct packed {
		logic [CFG_BYTES*BYTE_W-1:0] pattern;
		logic [LEN_W-1:0]            plen;
		logic [CFG_BYTES*BYTE_W-1:0] repl;
		logic [LEN_W-1:0]            rlen;
		logic                        every;
	} cfg_t;

	typedef struct packed {
		logic               load;
		logic               fin;
		logic [TOTAL_W-1:0] total;
	} burst_t;

endpackage

// ===== rtl/fr_in_if.sv =====
// Interface: input text byte channel.
interface fr_in_if;
	import fr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ===== rtl/fr_out_if.sv =====
// Interface: output rewritten text channel.
interface fr_out_if;
	import fr_pkg::*;

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  out_byte;
	logic               byte_valid;
	logic               final_item;
	logic [TOTAL_W-1:0] match_total;

	modport source (output valid, output out_byte, output byte_valid, output final_item,
		output match_total, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input final_item,
		input match_total, output ready);
endinterface

// ===== rtl/fr_apb_regs.sv =====
// APB configuration registers of the find-and-replace block.
module fr_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fr_pkg::ADDR_W-1:0]  paddr,
	input  logic [fr_pkg::DATA_W-1:0]  pwdata,
	output logic [fr_pkg::DATA_W-1:0]  prdata,
	output logic                       pready,
	output fr_pkg::cfg_t               cfg
);
	import fr_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[ADDR_W-1:IDX_LSB];
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern <= '0;
			cfg_q.plen    <= '0;
			cfg_q.repl    <= '0;
			cfg_q.rlen    <= '0;
			cfg_q.every   <= 1'b1;
		end else if (wr) begin
			case (idx)
				REG_PATTERN:     cfg_q.pattern <= pwdata;
				REG_PATTERN_LEN: cfg_q.plen    <= pwdata[LEN_W-1:0];
				REG_REPLACE:     cfg_q.repl    <= pwdata;
				REG_REPLACE_LEN: cfg_q.rlen    <= pwdata[LEN_W-1:0];
				REG_EVERY:       cfg_q.every   <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PATTERN:     prdata = cfg_q.pattern;
			REG_PATTERN_LEN: prdata = DATA_W'(cfg_q.plen);
			REG_REPLACE:     prdata = cfg_q.repl;
			REG_REPLACE_LEN: prdata = DATA_W'(cfg_q.rlen);
			REG_EVERY:       prdata = DATA_W'(cfg_q.every);
			default:         prdata = '0;
		endcase
	end
endmodule

// ===== rtl/fr_cell.sv =====
// Window cell: holds one pending byte, compares it to its pattern byte, shifts to its neighbour.
module fr_cell (
	input  logic                      clk,
	input  logic                      en,
	input  logic                      load,
	input  logic                      shift,
	input  logic [fr_pkg::BYTE_W-1:0] in_byte,
	input  logic [fr_pkg::BYTE_W-1:0] nbr_byte,
	input  logic [fr_pkg::BYTE_W-1:0] pat_byte,
	output logic [fr_pkg::BYTE_W-1:0] post_byte,
	output logic                      eq
);
	import fr_pkg::*;

	logic [BYTE_W-1:0] cell_q;

	assign post_byte = load ? in_byte : cell_q;
	assign eq        = (post_byte == pat_byte);

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= shift ? nbr_byte : post_byte;
		end
	end
endmodule

// ===== rtl/fr_emit.sv =====
// Output stage: shift row of result bytes, hands out one transaction per cycle while the receiver is ready.
module fr_emit #(
	parameter int NB = 8,
	parameter int NW = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fr_pkg::burst_t                 ctl,
	input  logic [NW-1:0]                  ld_count,
	input  logic [NB-1:0][fr_pkg::BYTE_W-1:0] ld_bytes,
	output logic                           can_load,
	fr_out_if.source                       text_out
);
	import fr_pkg::*;

	logic [NW-1:0]             rem_q;
	logic                      fin_q;
	logic                      bv_q;
	logic [TOTAL_W-1:0]        total_q;
	logic [NB-1:0][BYTE_W-1:0] slot_q;
	logic                      last;
	logic                      take;

	assign last     = (rem_q == NW'(1));
	assign take     = text_out.valid && text_out.ready;
	assign can_load = (rem_q == '0) || (last && text_out.ready);

	assign text_out.valid       = (rem_q != '0);
	assign text_out.out_byte    = bv_q ? slot_q[0] : '0;
	assign text_out.byte_valid  = bv_q;
	assign text_out.final_item  = fin_q && last;
	assign text_out.match_total = (fin_q && last) ? total_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			fin_q <= 1'b0;
		end else if (ctl.load) begin
			rem_q <= (ld_count == '0 && ctl.fin) ? NW'(1) : ld_count;
			fin_q <= ctl.fin;
		end else if (take) begin
			rem_q <= rem_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slot_q  <= ld_bytes;
			bv_q    <= (ld_count != '0);
			total_q <= ctl.total;
		end else if (take) begin
			for (int j = 0; j < NB - 1; j++) begin
				slot_q[j] <= slot_q[j+1];
			end
		end
	end

`ifndef SYNTHESIS
	a_total_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		text_out.valid && !text_out.final_item |-> text_out.match_total == '0)
		else $error("match total shown on a non-final transaction");
	a_bare_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		text_out.valid && !text_out.byte_valid |-> text_out.final_item)
		else $error("bare transaction that is not final");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= NW'(NB))
		else $error("result count beyond row length");
`endif
endmodule

// ===== rtl/byte_stream_find_and_replace.sv =====
// Top level: streaming find-and-replace over a byte stream, window held in a row of cells.
//
//  channel   | dir | payload                                       | accepted when
//  text_in   | in  | in_byte, end_of_text                          | valid && ready
//  text_out  | out | out_byte, byte_valid, final_item, match_total | valid && ready
//  apb       | in  | paddr, pwdata (64 bit), prdata                | psel, penable, pwrite
//
// One input transaction per cycle while the output row can take it; each gives 0 to
// max(MAX_PATTERN, MAX_REPLACEMENT) results, and the output row hands out one result per
// cycle while the receiver is ready; the input waits until the row's last result is taken.
// The window compare across all cells completes in the accepting cycle.
// Reset clears fill, match state, count and the output row; configuration gets its defaults.
// A stalled output holds the input once the output row is loaded.
module byte_stream_find_and_replace #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8,
	parameter int COUNT_WIDTH     = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fr_pkg::ADDR_W-1:0]  paddr,
	input  logic [fr_pkg::DATA_W-1:0]  pwdata,
	output logic [fr_pkg::DATA_W-1:0]  prdata,
	output logic                       pready,
	fr_in_if.sink                      text_in,
	fr_out_if.source                   text_out
);
	import fr_pkg::*;

	localparam int FW = $clog2(MAX_PATTERN + 1);
	localparam int LW = (FW > LEN_W) ? FW : LEN_W;
	localparam int NB = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int NW = $clog2(NB + 1);

	cfg_t                               cfg;
	logic [FW-1:0]                      fill_q;
	logic                               done_q;
	logic [COUNT_WIDTH-1:0]             cnt_q;
	logic [COUNT_WIDTH-1:0]             cnt_nxt;
	logic [LW-1:0]                      plen;
	logic [LW-1:0]                      fill_post;
	logic [NW-1:0]                      rlen;
	logic [NW-1:0]                      n_res;
	logic                               accept;
	logic                               eot;
	logic                               active;
	logic                               flush;
	logic                               at_len;
	logic                               hit;
	logic                               miss;
	logic                               can_load;
	logic [TOTAL_W-1:0]                 total;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] post;
	logic [MAX_PATTERN-1:0]             eq;
	logic [MAX_PATTERN-1:0]             eq_ok;
	logic [NB-1:0][BYTE_W-1:0]          win_bytes;
	logic [NB-1:0][BYTE_W-1:0]          rep_bytes;
	logic [NB-1:0][BYTE_W-1:0]          ld_bytes;
	burst_t                             ctl;

	fr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign text_in.ready = can_load;
	assign accept        = text_in.valid && text_in.ready;
	assign eot           = text_in.end_of_text;

	assign plen      = (cfg.plen > MAX_PATTERN) ? LW'(MAX_PATTERN) : LW'(cfg.plen);
	assign rlen      = (cfg.rlen > MAX_REPLACEMENT) ? NW'(MAX_REPLACEMENT) : NW'(cfg.rlen);
	assign fill_post = LW'(fill_q) + LW'(1);

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [BYTE_W-1:0] pat_b;
		logic [BYTE_W-1:0] nbr_b;

		if (i < CFG_BYTES) begin : g_pat
			assign pat_b = cfg.pattern[BYTE_W*i +: BYTE_W];
		end else begin : g_nopat
			assign pat_b = '0;
		end

		if (i < MAX_PATTERN - 1) begin : g_nbr
			assign nbr_b = post[i+1];
		end else begin : g_end
			assign nbr_b = post[i];
		end

		fr_cell u_cell (
			.clk       (clk),
			.en        (accept),
			.load      (fill_q == FW'(i)),
			.shift     (miss),
			.in_byte   (text_in.in_byte),
			.nbr_byte  (nbr_b),
			.pat_byte  (pat_b),
			.post_byte (post[i]),
			.eq        (eq[i])
		);

		assign eq_ok[i] = eq[i] || (LW'(i) >= plen);
	end

	for (genvar j = 0; j < NB; j++) begin : g_slot
		if (j < MAX_PATTERN) begin : g_win
			assign win_bytes[j] = post[j];
		end else begin : g_nowin
			assign win_bytes[j] = '0;
		end
		if (j < CFG_BYTES && j < MAX_REPLACEMENT) begin : g_rep
			assign rep_bytes[j] = cfg.repl[BYTE_W*j +: BYTE_W];
		end else begin : g_norep
			assign rep_bytes[j] = '0;
		end
	end

	assign active = (plen != '0) && (cfg.every || !done_q);
	assign flush  = !active || (fill_post > plen);
	assign at_len = active && (fill_post == plen);
	assign hit    = at_len && (&eq_ok);
	assign miss   = at_len && !hit;

	assign cnt_nxt  = (hit && cnt_q != '1) ? cnt_q + COUNT_WIDTH'(1) : cnt_q;
	assign ld_bytes = hit ? rep_bytes : win_bytes;

	if (COUNT_WIDTH > TOTAL_W) begin : g_sat
		assign total = (cnt_nxt > COUNT_WIDTH'({TOTAL_W{1'b1}})) ? '1 : cnt_nxt[TOTAL_W-1:0];
	end else begin : g_ext
		assign total = TOTAL_W'(cnt_nxt);
	end

	always_comb begin
		if (hit) begin
			n_res = rlen;
		end else if (flush || eot) begin
			n_res = NW'(fill_post);
		end else if (miss) begin
			n_res = NW'(1);
		end else begin
			n_res = '0;
		end
		ctl.load  = accept;
		ctl.fin   = eot;
		ctl.total = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (eot || flush || hit) begin
				fill_q <= '0;
			end else if (!miss) begin
				fill_q <= fill_post[FW-1:0];
			end
			done_q <= eot ? 1'b0 : (done_q || hit);
			cnt_q  <= eot ? '0 : cnt_nxt;
		end
	end

	fr_emit #(
		.NB (NB),
		.NW (NW)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.ld_count (n_res),
		.ld_bytes (ld_bytes),
		.can_load (can_load),
		.text_out (text_out)
	);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_PATTERN - 1))
		else $error("window fill beyond pattern capacity");
	a_eot_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		accept && eot |=> fill_q == '0 && !done_q && cnt_q == '0)
		else $error("state not rearmed after end of text");
	a_hit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && hit |=> fill_q == '0 && (done_q || $past(eot)))
		else $error("window not cleared after a match");
`endif
endmodule

// ===== verif/tb.sv =====
// Testbench: self-checking stream test of the byte find-and-replace block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fr_pkg::*;

	localparam int WIN_DEPTH    = 8;
	localparam int REPL_DEPTH   = 8;
	localparam int SETTLE_CYCLES = 24;
	localparam int PRINT_LIMIT  = 100;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               byte_valid;
		logic               final_item;
		logic [TOTAL_W-1:0] match_total;
	} text_result_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	fr_in_if  text_in ();
	fr_out_if text_out ();

	byte_stream_find_and_replace dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.text_in  (text_in),
		.text_out (text_out)
	);

	// shadow of the block's registers and matching state
	cfg_t               rule_cfg = '{pattern: '0, plen: '0, repl: '0, rlen: '0, every: 1'b1};
	logic [BYTE_W-1:0]  win [WIN_DEPTH];
	int unsigned        win_fill = 0;
	logic               done_once = 1'b0;
	logic [TOTAL_W-1:0] match_count = '0;

	text_result_t rewritten_q [$];

	int mismatches     = 0;
	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int hold_cycles    = 0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic void set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_gap_pct = 87;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_gap_pct = 0;
				recv_stall_pct = 87;
			end
			default: begin
				send_gap_pct = 11;
				recv_stall_pct = 11;
			end
		endcase
	endfunction

	function automatic text_result_t byte_result(input logic [BYTE_W-1:0] b);
		text_result_t r;
		r = '0;
		r.out_byte = b;
		r.byte_valid = 1'b1;
		return r;
	endfunction

	function automatic void spill_window(ref text_result_t q [$]);
		int unsigned i;
		for (i = 0; i < win_fill; i++)
			q.push_back(byte_result(win[i]));
		win_fill = 0;
	endfunction

	// rewritten text caused by one accepted byte
	function automatic void rewrite_byte(input logic [BYTE_W-1:0] b, input logic eot);
		text_result_t step_q [$];
		text_result_t item;
		int unsigned  plen, rlen, i;
		logic         active, hit;
		plen = (rule_cfg.plen > WIN_DEPTH) ? WIN_DEPTH : rule_cfg.plen;
		rlen = (rule_cfg.rlen > REPL_DEPTH) ? REPL_DEPTH : rule_cfg.rlen;
		active = (plen != 0) && (rule_cfg.every || !done_once);
		if (win_fill > WIN_DEPTH - 1)
			win_fill = WIN_DEPTH - 1;
		win[win_fill] = b;
		win_fill++;
		if (!active || win_fill > plen) begin
			spill_window(step_q);
		end else if (win_fill == plen) begin
			hit = 1'b1;
			for (i = 0; i < plen; i++)
				if (win[i] != rule_cfg.pattern[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				for (i = 0; i < rlen; i++)
					step_q.push_back(byte_result(rule_cfg.repl[8*i +: 8]));
				win_fill = 0;
				done_once = 1'b1;
				if (match_count != '1)
					match_count++;
			end else begin
				step_q.push_back(byte_result(win[0]));
				for (i = 1; i < win_fill; i++)
					win[i-1] = win[i];
				win_fill--;
			end
		end
		if (eot) begin
			spill_window(step_q);
			if (step_q.size() == 0) begin
				item = '0;
				step_q.push_back(item);
			end
			item = step_q.pop_back();
			item.final_item = 1'b1;
			item.match_total = match_count;
			step_q.push_back(item);
			done_once = 1'b0;
			match_count = '0;
		end
		foreach (step_q[j])
			rewritten_q.push_back(step_q[j]);
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << IDX_LSB;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_PATTERN:     rule_cfg.pattern = value;
			REG_PATTERN_LEN: rule_cfg.plen = value[LEN_W-1:0];
			REG_REPLACE:     rule_cfg.repl = value;
			REG_REPLACE_LEN: rule_cfg.rlen = value[LEN_W-1:0];
			REG_EVERY:       rule_cfg.every = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// sender pause: valid low until every result is in, then let the block settle
	task automatic wait_drained();
		@(negedge clk);
		text_in.valid <= 1'b0;
		while (rewritten_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic load_rule(input logic [DATA_W-1:0] pat, input logic [LEN_W-1:0] plen,
		input logic [DATA_W-1:0] repl, input logic [LEN_W-1:0] rlen, input logic every);
		wait_drained();
		write_reg(REG_PATTERN, pat);
		write_reg(REG_PATTERN_LEN, DATA_W'(plen));
		write_reg(REG_REPLACE, repl);
		write_reg(REG_REPLACE_LEN, DATA_W'(rlen));
		write_reg(REG_EVERY, DATA_W'(every));
	endtask

	task automatic send_text_byte(input logic [BYTE_W-1:0] b, input logic eot);
		@(negedge clk);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			text_in.valid <= 1'b0;
			@(negedge clk);
		end
		text_in.valid <= 1'b1;
		text_in.in_byte <= b;
		text_in.end_of_text <= eot;
		@(posedge clk);
		while (!text_in.ready)
			@(posedge clk);
		rewrite_byte(b, eot);
	endtask

	initial begin
		text_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				text_out.ready <= 1'b0;
				hold_cycles--;
			end else begin
				text_out.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin : result_check
		text_result_t got;
		text_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && text_out.valid && text_out.ready) begin
				got.out_byte = text_out.out_byte;
				got.byte_valid = text_out.byte_valid;
				got.final_item = text_out.final_item;
				got.match_total = text_out.match_total;
				@(negedge clk);
				if (rewritten_q.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction %p", got));
				end else begin
					want = rewritten_q.pop_front();
					if (got.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %h, want %h",
							got.out_byte, want.out_byte));
					if (got.byte_valid !== want.byte_valid)
						report_mismatch($sformatf("byte_valid %b, want %b",
							got.byte_valid, want.byte_valid));
					if (got.final_item !== want.final_item)
						report_mismatch($sformatf("final_item %b, want %b",
							got.final_item, want.final_item));
					if (got.match_total !== want.match_total)
						report_mismatch($sformatf("match_total %0d, want %0d",
							got.match_total, want.match_total));
				end
			end
		end
	end

	// registers at their reset values: plain pass-through
	task automatic test_pass_through();
		set_idling(IDLE_NONE);
		send_text_byte(8'h00, 1'b0);
		send_text_byte(8'hFF, 1'b0);
		send_text_byte(8'h5A, 1'b0);
		send_text_byte(8'hA5, 1'b1);
	endtask

	// oversize lengths clamp to a full eight-byte pattern and replacement
	task automatic test_full_width_match();
		logic [DATA_W-1:0] pat;
		int i;
		pat = 64'hFE7F_8001_AA55_FF00;
		load_rule(pat, 4'd15, 64'h00FF_0123_4567_89AB, 4'd9, 1'b1);
		for (i = 0; i < 8; i++)
			send_text_byte(pat[8*i +: 8], i == 7);
	endtask

	// partial match, resume after a hit, deletion and a bare end transaction
	task automatic test_deletion_at_end();
		load_rule(64'h6261, 4'd2, 64'h0, 4'd0, 1'b1);
		send_text_byte(8'h61, 1'b0);
		send_text_byte(8'h61, 1'b0);
		send_text_byte(8'h62, 1'b0);
		send_text_byte(8'h61, 1'b0);
		send_text_byte(8'h62, 1'b1);
	endtask

	task automatic test_first_only();
		load_rule(64'h78, 4'd1, 64'h5A59, 4'd2, 1'b0);
		send_text_byte(8'h78, 1'b0);
		send_text_byte(8'h78, 1'b0);
		send_text_byte(8'h78, 1'b1);
	endtask

	// pattern cut down while bytes are held in the window
	task automatic test_shortened_pattern();
		load_rule(64'h6463_6261, 4'd4, 64'h2A, 4'd1, 1'b1);
		send_text_byte(8'h61, 1'b0);
		send_text_byte(8'h62, 1'b0);
		send_text_byte(8'h63, 1'b0);
		wait_drained();
		write_reg(REG_PATTERN_LEN, DATA_W'(2));
		send_text_byte(8'h71, 1'b1);
	endtask

	// long output stall while the sender keeps offering bytes
	task automatic test_output_stall();
		logic [BYTE_W-1:0] hit_byte;
		int i;
		hit_byte = 8'($urandom);
		load_rule(DATA_W'(hit_byte), 4'd1, {$urandom, $urandom}, 4'd8, 1'b1);
		set_idling(IDLE_NONE);
		hold_cycles = 400;
		for (i = 0; i < 30; i++)
			send_text_byte(($urandom_range(1) == 0) ? hit_byte : 8'($urandom), i == 29);
	endtask

	task automatic test_random_text(input idle_mode_t mode, input int n_items);
		logic [BYTE_W-1:0] sym [2];
		logic [DATA_W-1:0] pat;
		logic [LEN_W-1:0]  plen, rlen;
		int unsigned       eff_len, cut, sent, next_rule, i, pick;
		set_idling(mode);
		sent = 0;
		next_rule = 0;
		eff_len = 0;
		while (sent < n_items) begin
			if (sent >= next_rule) begin
				sym[0] = 8'($urandom);
				sym[1] = 8'($urandom);
				pat = {$urandom, $urandom};
				for (i = 0; i < 8; i++)
					pat[8*i +: 8] = sym[$urandom_range(1)];
				case ($urandom_range(5))
					0: begin
						plen = 4'd8;
						rlen = 4'd8;
					end
					1: begin
						plen = 4'd1;
						rlen = 4'd0;
					end
					2: begin
						plen = 4'($urandom_range(15));
						rlen = 4'($urandom_range(15));
					end
					default: begin
						plen = 4'($urandom_range(8, 1));
						rlen = 4'($urandom_range(8));
					end
				endcase
				load_rule(pat, plen, {$urandom, $urandom}, rlen, $urandom_range(3) != 0);
				eff_len = (plen > WIN_DEPTH) ? WIN_DEPTH : plen;
				next_rule = sent + 25;
			end
			pick = $urandom_range(99);
			if (pick < 45 && eff_len != 0) begin
				cut = ($urandom_range(3) == 0) ? $urandom_range(eff_len) : eff_len;
				for (i = 0; i < cut; i++) begin
					send_text_byte(pat[8*i +: 8], $urandom_range(15) == 0);
					sent++;
				end
			end else if (pick < 90) begin
				send_text_byte(sym[$urandom_range(1)], $urandom_range(15) == 0);
				sent++;
			end else begin
				send_text_byte(8'($urandom), $urandom_range(15) == 0);
				sent++;
			end
			if ($urandom_range(19) == 0)
				wait_drained();
		end
		send_text_byte(8'($urandom), 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		text_in.valid = 1'b0;
		text_in.in_byte = '0;
		text_in.end_of_text = 1'b0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pass_through();
		test_full_width_match();
		test_deletion_at_end();
		test_first_only();
		test_shortened_pattern();
		test_output_stall();
		test_random_text(IDLE_NONE, 100);
		test_random_text(IDLE_SEND, 100);
		test_random_text(IDLE_RECV, 100);
		test_random_text(IDLE_BOTH, 100);
		wait_drained();

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
